// ===== src/sptg_pkg.sv =====
// ----------------------------------------------------------------------------
// sptg_pkg: shared types and constants of the swept pulse train generator
// register indexes, configuration bundle and reset constants
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sptg_pkg;

  // default number of samples in the first block after a restart
  localparam int unsigned BlockSizeDefault = 1024;
  // reset distance and sweep length are the block size over this divisor
  localparam int unsigned DistanceDivisor = 10;

  // configuration port geometry
  localparam int unsigned PaddrWidth = 5;
  localparam int unsigned PdataWidth = 32;

  // register indexes, byte address is four times the index
  typedef enum logic [2:0] {
    REG_PULSE_WIDTH       = 3'd0,
    REG_AMPLITUDE         = 3'd1,
    REG_POSITIVE_POLARITY = 3'd2,
    REG_INITIAL_DISTANCE  = 3'd3,
    REG_START_DELAY       = 3'd4,
    REG_DISTANCE_STEP     = 3'd5,
    REG_SWEEP_PERIOD      = 3'd6
  } reg_index_t;

  // configuration bundle handed from the register file to the datapath
  typedef struct packed {
    logic [15:0]        pulse_width;
    logic [15:0]        amplitude;
    logic               positive_polarity;
    logic [31:0]        initial_distance;
    logic [15:0]        start_delay;
    logic signed [15:0] distance_step;
    logic [31:0]        sweep_period;
  } cfg_t;

endpackage

`default_nettype wire

// ===== src/sptg_regs.sv =====
// ----------------------------------------------------------------------------
// sptg_regs: configuration register file
// APB-style write and read access to the seven generator registers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sptg_regs
  import sptg_pkg::*;
#(
  parameter int unsigned BLOCK_SIZE = BlockSizeDefault
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [PaddrWidth-1:0] paddr,
  input  wire logic [PdataWidth-1:0] pwdata,
  output      logic [PdataWidth-1:0] prdata,
  output      logic                  pready,
  output      cfg_t                  cfg
);

  localparam logic [31:0] DistReset = 32'(BLOCK_SIZE / DistanceDivisor);

  reg_index_t index;
  logic       wr_en;

  assign index  = reg_index_t'(paddr[PaddrWidth-1:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // register writes, unmapped indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulse_width       <= 16'd1;
      cfg.amplitude         <= 16'd32768;
      cfg.positive_polarity <= 1'b1;
      cfg.initial_distance  <= DistReset;
      cfg.start_delay       <= 16'd0;
      cfg.distance_step     <= 16'sd0;
      cfg.sweep_period      <= DistReset;
    end else if (wr_en) begin
      unique case (index)
        REG_PULSE_WIDTH:       cfg.pulse_width       <= pwdata[15:0];
        REG_AMPLITUDE:         cfg.amplitude         <= pwdata[15:0];
        REG_POSITIVE_POLARITY: cfg.positive_polarity <= pwdata[0];
        REG_INITIAL_DISTANCE:  cfg.initial_distance  <= pwdata[31:0];
        REG_START_DELAY:       cfg.start_delay       <= pwdata[15:0];
        REG_DISTANCE_STEP:     cfg.distance_step     <= signed'(pwdata[15:0]);
        REG_SWEEP_PERIOD:      cfg.sweep_period      <= pwdata[31:0];
        default: begin
        end
      endcase
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    unique case (index)
      REG_PULSE_WIDTH:       prdata = {16'd0, cfg.pulse_width};
      REG_AMPLITUDE:         prdata = {16'd0, cfg.amplitude};
      REG_POSITIVE_POLARITY: prdata = {31'd0, cfg.positive_polarity};
      REG_INITIAL_DISTANCE:  prdata = cfg.initial_distance;
      REG_START_DELAY:       prdata = {16'd0, cfg.start_delay};
      REG_DISTANCE_STEP:     prdata = {16'd0, cfg.distance_step};
      REG_SWEEP_PERIOD:      prdata = cfg.sweep_period;
      default:               prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/swept_pulse_train_generator.sv =====
// ----------------------------------------------------------------------------
// swept_pulse_train_generator: pulse train with swept pulse distance
// one output sample per input transaction, configured over an APB-style port
// ----------------------------------------------------------------------------
// Each accepted input transaction yields exactly one output transaction, and a
// new input is taken every cycle while the output register is empty or being
// drained, so the block sustains one sample per clock. The whole update
// (pulse-width compare, distance compare, 32-bit increments and the signed
// distance step) sits between the pulse state registers and the output
// register. restart reloads the state before its own sample is made; the first
// min(start_delay, BLOCK_SIZE) samples after a restart or reset are zero.
// Users must write registers only with no transaction outstanding; unenforced.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swept_pulse_train_generator
  import sptg_pkg::*;
#(
  parameter int unsigned BLOCK_SIZE = BlockSizeDefault
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // configuration port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [PaddrWidth-1:0] paddr,
  input  wire logic [PdataWidth-1:0] pwdata,
  output      logic [PdataWidth-1:0] prdata,
  output      logic                  pready,
  // input channel
  input  wire logic                  in_valid,
  output      logic                  in_ready,
  input  wire logic                  restart,
  // output channel
  output      logic                  out_valid,
  input  wire logic                  out_ready,
  output      logic signed [16:0]    sample,
  output      logic                  pulse_active
);

  localparam int unsigned IdxWidth = $clog2(BLOCK_SIZE + 1);
  localparam logic [31:0] DistReset = 32'(BLOCK_SIZE / DistanceDivisor);
  localparam logic [31:0] BlockLen  = 32'(BLOCK_SIZE);

  cfg_t cfg;

  sptg_regs #(
    .BLOCK_SIZE (BLOCK_SIZE)
  ) u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // pulse state
  logic [31:0]         phase_position, phase_position_next;
  logic [31:0]         sweep_count, sweep_count_next;
  logic [31:0]         current_distance, current_distance_next;
  logic [IdxWidth-1:0] first_block_index, first_block_index_next;

  logic                accept;
  logic [31:0]         pos_eff, cnt_eff, dist_eff, cnt_inc;
  logic [IdxWidth-1:0] idx_eff;
  logic                in_first, skipped, in_pulse;
  logic signed [16:0]  sample_next;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // restart reloads the state before this sample
  assign pos_eff  = restart ? 32'd0 : phase_position;
  assign cnt_eff  = restart ? 32'd0 : sweep_count;
  assign dist_eff = restart ? cfg.initial_distance : current_distance;
  assign idx_eff  = restart ? '0 : first_block_index;

  assign in_first = 32'(idx_eff) < BlockLen;
  assign skipped  = in_first && (32'(idx_eff) < 32'(cfg.start_delay));
  assign in_pulse = !skipped && (pos_eff < 32'(cfg.pulse_width));
  assign cnt_inc  = cnt_eff + 32'd1;

  // next state and sample
  always_comb begin
    first_block_index_next = in_first ? idx_eff + IdxWidth'(1) : idx_eff;
    phase_position_next    = pos_eff;
    sweep_count_next       = cnt_eff;
    current_distance_next  = dist_eff;
    if (!skipped) begin
      priority if (in_pulse) begin
        phase_position_next = pos_eff + 32'd1;
        sweep_count_next    = cnt_inc;
      end else if (pos_eff == dist_eff) begin
        phase_position_next = 32'd0;
        if (cnt_inc <= cfg.sweep_period) begin
          sweep_count_next      = cnt_inc;
          current_distance_next = dist_eff + 32'(cfg.distance_step);
        end else begin
          sweep_count_next      = 32'd0;
          current_distance_next = cfg.initial_distance;
        end
      end else begin
        phase_position_next = pos_eff + 32'd1;
        sweep_count_next    = cnt_inc;
      end
    end
    sample_next = cfg.positive_polarity ? signed'({1'b0, cfg.amplitude})
                                        : -signed'({1'b0, cfg.amplitude});
    if (!in_pulse) begin
      sample_next = '0;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_position    <= 32'd0;
      sweep_count       <= 32'd0;
      current_distance  <= DistReset;
      first_block_index <= '0;
    end else if (accept) begin
      phase_position    <= phase_position_next;
      sweep_count       <= sweep_count_next;
      current_distance  <= current_distance_next;
      first_block_index <= first_block_index_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample       <= sample_next;
      pulse_active <= in_pulse;
    end
  end

  // checks
  a_result_follows : assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted transaction produced no result");

  a_idle_is_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && !pulse_active |-> sample == 17'sd0)
    else $error("nonzero sample outside a pulse");

  a_restart_skips : assert property (@(posedge clk) disable iff (rst)
    accept && restart && cfg.start_delay != 16'd0 |=> out_valid && !pulse_active)
    else $error("restart with start delay did not skip the first sample");

  a_index_bound : assert property (@(posedge clk) disable iff (rst)
    32'(first_block_index) <= BlockLen)
    else $error("first block index ran past block size");

endmodule

`default_nettype wire

// ===== sim/sptg_checker.sv =====
// ----------------------------------------------------------------------------
// sptg_checker: scoreboard for the swept pulse train generator
// tracks register writes on the APB-style port, predicts one sample per
// accepted input transaction and compares it with the next output transaction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sptg_checker
  import sptg_pkg::*;
#(
  parameter int unsigned BLOCK_SIZE = BlockSizeDefault
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic                  pready,
  input  wire logic [PaddrWidth-1:0] paddr,
  input  wire logic [PdataWidth-1:0] pwdata,
  input  wire logic                  in_valid,
  input  wire logic                  in_ready,
  input  wire logic                  restart,
  input  wire logic                  out_valid,
  input  wire logic                  out_ready,
  input  wire logic signed [16:0]    sample,
  input  wire logic                  pulse_active,
  output int                         outstanding,
  output int                         mismatch_count
);

  typedef struct packed {
    logic signed [16:0] level;
    logic               active;
  } gen_out_t;

  // shadow registers and generator state
  cfg_t        regs;
  logic [31:0] position;
  logic [31:0] sweep_count;
  logic [31:0] distance;
  int unsigned block_index;
  gen_out_t    expected_samples[$];

  function automatic cfg_t reset_regs();
    cfg_t c;
    c.pulse_width       = 16'd1;
    c.amplitude         = 16'd32768;
    c.positive_polarity = 1'b1;
    c.initial_distance  = 32'(BLOCK_SIZE / DistanceDivisor);
    c.start_delay       = 16'd0;
    c.distance_step     = 16'sd0;
    c.sweep_period      = 32'(BLOCK_SIZE / DistanceDivisor);
    return c;
  endfunction

  task automatic reload_generator();
    position    = '0;
    sweep_count = '0;
    distance    = regs.initial_distance;
    block_index = 0;
  endtask

  // one sample of the generator, state advances in place
  task automatic step_pulse_train(input logic rs, output gen_out_t res);
    int unsigned skip;
    logic        skipped;
    skip    = (regs.start_delay < BLOCK_SIZE) ? regs.start_delay : BLOCK_SIZE;
    skipped = 1'b0;
    res     = '0;
    if (rs) reload_generator();
    if (block_index < BLOCK_SIZE) begin
      skipped = (block_index < skip);
      block_index++;
    end
    if (!skipped) begin
      if (position < {16'd0, regs.pulse_width}) begin
        // inside the pulse
        res.active = 1'b1;
        res.level  = regs.positive_polarity ? $signed({1'b0, regs.amplitude})
                                            : -$signed({1'b0, regs.amplitude});
        position++;
        sweep_count++;
      end else if (position == distance) begin
        // pulse cycle done, sweep the distance or reload it
        position = '0;
        sweep_count++;
        if (sweep_count <= regs.sweep_period) begin
          distance = distance + {{16{regs.distance_step[15]}}, regs.distance_step};
        end else begin
          distance    = regs.initial_distance;
          sweep_count = '0;
        end
      end else begin
        position++;
        sweep_count++;
      end
    end
  endtask

  task automatic count_failure(input string what, input gen_out_t want, input gen_out_t got);
    if (mismatch_count < 10) begin
      $display("%0t: %s: sample exp %0d got %0d, pulse_active exp %0b got %0b",
               $time, what, want.level, got.level, want.active, got.active);
    end
    mismatch_count++;
  endtask

  // monitor both channels and the register port
  always @(posedge clk) begin
    gen_out_t want;
    gen_out_t got;
    if (rst) begin
      regs = reset_regs();
      reload_generator();
      expected_samples.delete();
      mismatch_count = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_index_t'(paddr[PaddrWidth-1:2]))
          REG_PULSE_WIDTH:       regs.pulse_width       = pwdata[15:0];
          REG_AMPLITUDE:         regs.amplitude         = pwdata[15:0];
          REG_POSITIVE_POLARITY: regs.positive_polarity = pwdata[0];
          REG_INITIAL_DISTANCE:  regs.initial_distance  = pwdata;
          REG_START_DELAY:       regs.start_delay       = pwdata[15:0];
          REG_DISTANCE_STEP:     regs.distance_step     = pwdata[15:0];
          REG_SWEEP_PERIOD:      regs.sweep_period      = pwdata;
          default: ;
        endcase
      end
      // predict first so a same-edge output could still find its entry
      if (in_valid && in_ready) begin
        step_pulse_train(restart, want);
        expected_samples.push_back(want);
      end
      if (out_valid && out_ready) begin
        got.level  = sample;
        got.active = pulse_active;
        if (expected_samples.size() == 0) begin
          count_failure("output transaction with nothing expected", '0, got);
        end else begin
          want = expected_samples.pop_front();
          if (got.level !== want.level || got.active !== want.active) begin
            count_failure("mismatch", want, got);
          end
        end
      end
    end
    outstanding <= expected_samples.size();
  end

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for the swept pulse train generator
// drives directed and random sample requests with random gaps and output
// stalls, reprograms the registers between phases, and reports the verdict
// from the checker's failure count
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import sptg_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned IdlePct    = 21;
  localparam int unsigned HoldCycles = 150;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [PaddrWidth-1:0] paddr     = '0;
  logic [PdataWidth-1:0] pwdata    = '0;
  logic [PdataWidth-1:0] prdata;
  logic                  pready;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  logic                  restart   = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic signed [16:0]    sample;
  logic                  pulse_active;

  int          outstanding;
  int          mismatch_count;
  int unsigned cycle_count = 0;
  int unsigned rx_count    = 0;
  int unsigned hold_left   = 0;
  logic        calm;

  // window where neither side idles
  assign calm = (cycle_count >= 1500) && (cycle_count < 2300);

  always #10 clk = ~clk;

  swept_pulse_train_generator u_top (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .restart      (restart),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sample       (sample),
    .pulse_active (pulse_active)
  );

  sptg_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .restart        (restart),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .sample         (sample),
    .pulse_active   (pulse_active),
    .outstanding    (outstanding),
    .mismatch_count (mismatch_count)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAIL swept_pulse_train_generator");
      $finish;
    end
  end

  // output side: random stalls plus two long hold-offs that back up the input
  always @(posedge clk) begin
    if (out_valid && out_ready) rx_count <= rx_count + 1;
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (out_valid && out_ready && (rx_count + 1 == 300 || rx_count + 1 == 900)) begin
      out_ready <= 1'b0;
      hold_left <= HoldCycles;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= IdlePct);
    end
  end

  task automatic write_reg(input reg_index_t idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic load_config(input cfg_t c);
    write_reg(REG_PULSE_WIDTH, {16'd0, c.pulse_width});
    write_reg(REG_AMPLITUDE, {16'd0, c.amplitude});
    write_reg(REG_POSITIVE_POLARITY, {31'd0, c.positive_polarity});
    write_reg(REG_INITIAL_DISTANCE, c.initial_distance);
    write_reg(REG_START_DELAY, {16'd0, c.start_delay});
    write_reg(REG_DISTANCE_STEP, {16'd0, c.distance_step});
    write_reg(REG_SWEEP_PERIOD, c.sweep_period);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // one input transaction, with a random gap ahead of it
  task automatic send_item(input logic rs);
    int unsigned gap;
    gap = 0;
    while (!calm && $urandom_range(99) < IdlePct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    restart  <= rs;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic play(input int n, input int unsigned restart_pct, input logic lead_restart);
    for (int i = 0; i < n; i++) begin
      send_item((i == 0) ? lead_restart : ($urandom_range(99) < restart_pct));
    end
  endtask

  // stop offering and let the block go idle
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // mostly short pulses and distances so sweeps wrap around often
  function automatic cfg_t random_config();
    cfg_t c;
    c.pulse_width       = ($urandom_range(99) < 80) ? 16'($urandom_range(8)) : 16'($urandom);
    c.amplitude         = 16'($urandom);
    c.positive_polarity = 1'($urandom_range(1));
    c.initial_distance  = ($urandom_range(99) < 85) ? 32'($urandom_range(24)) : $urandom;
    c.start_delay       = 16'($urandom_range(40));
    c.distance_step     = ($urandom_range(99) < 70) ? 16'($signed($urandom_range(8)) - 4)
                                                    : 16'($urandom);
    c.sweep_period      = ($urandom_range(99) < 80) ? 32'($urandom_range(80)) : $urandom;
    return c;
  endfunction

  initial begin
    cfg_t c;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset defaults, then a restart in the middle
    play(3, 0, 1'b0);
    play(3, 0, 1'b1);
    settle();

    // negative full-scale pulses after a short delay, sweep ends at once
    c = '{pulse_width: 16'd3, amplitude: 16'hFFFF, positive_polarity: 1'b0,
          initial_distance: 32'd4, start_delay: 16'd2, distance_step: 16'h8000,
          sweep_period: 32'd0};
    load_config(c);
    play(8, 0, 1'b1);
    settle();

    // pulse wider than the distance, zero amplitude
    c = '{pulse_width: 16'd5, amplitude: 16'd0, positive_polarity: 1'b1,
          initial_distance: 32'd2, start_delay: 16'd0, distance_step: 16'h7FFF,
          sweep_period: 32'hFFFF_FFFF};
    load_config(c);
    play(8, 0, 1'b1);
    settle();

    // negative step wraps the distance below zero
    c = '{pulse_width: 16'd1, amplitude: 16'd1, positive_polarity: 1'b1,
          initial_distance: 32'd1, start_delay: 16'd0, distance_step: -16'sd5,
          sweep_period: 32'd10};
    load_config(c);
    play(4, 0, 1'b1);

    // random settings, the restart at the head is optional so stale distances show
    repeat (7) begin
      settle();
      c = random_config();
      load_config(c);
      play(50, 4, 1'($urandom_range(1)));
    end

    // delay beyond the block size: the whole first block is zero
    settle();
    c = random_config();
    c.start_delay      = 16'hFFFF;
    c.pulse_width      = 16'($urandom_range(1, 6));
    c.initial_distance = 32'($urandom_range(4, 30));
    load_config(c);
    play(1060, 0, 1'b1);

    settle();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS swept_pulse_train_generator");
    end else begin
      $display("FAIL swept_pulse_train_generator");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/sptg_pkg.sv
src/sptg_regs.sv
src/swept_pulse_train_generator.sv
sim/sptg_checker.sv
sim/tb_top.sv
